// ----- hdl/frame_buffer_slot_rotation_unit_assert.svh -----
// assertion macros for the frame buffer slot rotation unit
// uses clk_i and rst_ni of the module that includes it
`ifndef FRAME_BUFFER_SLOT_ROTATION_UNIT_ASSERT_SVH
`define FRAME_BUFFER_SLOT_ROTATION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked out of reset only
`define FBSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked in every cycle, reset included
`define FBSR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FBSR_ASSERT(name, prop, msg)
`define FBSR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- hdl/fbsr_pkg.sv -----
// types, constants and address helpers for the frame buffer slot rotation unit
// no dependencies
package fbsr_pkg;

  localparam int unsigned BUFFER_COUNT = 2;
  localparam int unsigned IDX_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;

  localparam logic [31:0] OFFSET_MASK = 32'h0fff_ffff;

  localparam logic [11:0] LINE_PIXELS_RST  = 12'd1920;
  localparam logic [11:0] FRAME_LINES_RST  = 12'd1080;
  localparam logic [31:0] REGION_BASE_RST  = 32'h0600_0000;
  localparam logic [27:0] BUFFER_BYTES_RST = 28'd8294400;

  typedef logic [IDX_W-1:0] buf_idx_t;

  typedef enum logic [1:0] {
    REG_LINE_PIXELS  = 2'd0,
    REG_FRAME_LINES  = 2'd1,
    REG_REGION_BASE  = 2'd2,
    REG_BUFFER_BYTES = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  event_bits;
    logic        slot0_dma_pending;
    logic [31:0] slot0_write_addr;
    logic        slot1_dma_pending;
    logic [31:0] slot1_write_addr;
  } item_t;

  typedef struct packed {
    logic        slot0_reload;
    logic [31:0] slot0_load_addr;
    logic        slot1_reload;
    logic [31:0] slot1_load_addr;
    logic [1:0]  pending_clear;
    logic [31:0] display_addr;
    logic [1:0]  length_error;
    logic [1:0]  stray_dma;
    logic [1:0]  spurious_event;
  } result_t;

  // what one slot sees of its interrupt event
  typedef struct packed {
    logic        event_bit;
    logic        dma_pending;
    logic [31:0] write_addr;
  } slot_in_t;

  // settings shared by both slots
  typedef struct packed {
    logic [31:0] region_base;
    logic [27:0] buffer_bytes;
    logic [31:0] expected;
    logic [31:0] lo;
    logic [31:0] hi;
  } slot_ctx_t;

  typedef struct packed {
    logic        good;
    logic        reload;
    logic [31:0] load_addr;
    logic        clr;
    logic        len_err;
    logic        stray;
    logic        spur;
  } slot_res_t;

  function automatic logic [31:0] buf_base(logic [31:0] region_base,
                                           logic [27:0] buffer_bytes,
                                           buf_idx_t n);
    logic [31:0] offs;
    offs = 32'(n) * {4'b0, buffer_bytes};
    return region_base + offs;
  endfunction

  function automatic buf_idx_t advance(buf_idx_t n);
    logic [IDX_W:0] inc;
    inc = (IDX_W+1)'(n) + (IDX_W+1)'(1);
    return (inc >= (IDX_W+1)'(BUFFER_COUNT)) ? '0 : inc[IDX_W-1:0];
  endfunction

endpackage

// ----- hdl/fbsr_if.sv -----
// valid/ready stream interfaces for event items and result items
// depends on nothing but the field widths below
interface fbsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_bits;
  logic        slot0_dma_pending;
  logic [31:0] slot0_write_addr;
  logic        slot1_dma_pending;
  logic [31:0] slot1_write_addr;

  modport source (output valid, event_bits, slot0_dma_pending, slot0_write_addr,
                  slot1_dma_pending, slot1_write_addr, input ready);
  modport sink (input valid, event_bits, slot0_dma_pending, slot0_write_addr,
                slot1_dma_pending, slot1_write_addr, output ready);
endinterface

interface fbsr_out_if;
  logic        valid;
  logic        ready;
  logic        slot0_reload;
  logic [31:0] slot0_load_addr;
  logic        slot1_reload;
  logic [31:0] slot1_load_addr;
  logic [1:0]  pending_clear;
  logic [31:0] display_addr;
  logic [1:0]  length_error;
  logic [1:0]  stray_dma;
  logic [1:0]  spurious_event;

  modport source (output valid, slot0_reload, slot0_load_addr, slot1_reload,
                  slot1_load_addr, pending_clear, display_addr, length_error,
                  stray_dma, spurious_event, input ready);
  modport sink (input valid, slot0_reload, slot0_load_addr, slot1_reload,
                slot1_load_addr, pending_clear, display_addr, length_error,
                stray_dma, spurious_event, output ready);
endinterface

// ----- hdl/frame_buffer_slot_rotation_unit.sv -----
// top level of the frame buffer slot rotation unit: input register, both slots,
// buffer rotation state and result register; depends on fbsr_pkg, fbsr_if, fbsr_slot and the assertion header
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   event bits, per-slot pending flag and write address
//   out_o    out  valid/ready   per-slot reload and address, clears, display, flags
//   cfg      in   cfg_we_i      register index cfg_idx_i, data cfg_wdata_i
//
// one event per clock when out_o is not stalled; from transfer to result an event passes
// the input register, then slot logic into the result register
// rotation state is read and written in the cycle an event moves into the result register
// reset empties both registers and loads the buffer indexes and settings defaults
// a stalled result holds its register while one more event waits in the input register
`include "frame_buffer_slot_rotation_unit_assert.svh"

module frame_buffer_slot_rotation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbsr_in_if.sink     in_i,
  fbsr_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [11:0] line_pixels_q;
  logic [11:0] frame_lines_q;
  logic [31:0] region_base_q;
  logic [27:0] buffer_bytes_q;

  fbsr_pkg::buf_idx_t slot0_buf_q, slot0_buf_d;
  fbsr_pkg::buf_idx_t slot1_buf_q, slot1_buf_d;
  fbsr_pkg::buf_idx_t next_buf_q, next_buf_d;
  fbsr_pkg::buf_idx_t shown_buf_q, shown_buf_d;
  fbsr_pkg::buf_idx_t next_mid;

  logic              in_valid_q;
  fbsr_pkg::item_t   in_q;
  logic              out_valid_q;
  fbsr_pkg::result_t out_q, out_d;

  logic adv;
  logic in_xfer;

  fbsr_pkg::slot_ctx_t ctx;
  fbsr_pkg::slot_in_t  s0_in, s1_in;
  fbsr_pkg::slot_res_t s0_res, s1_res;
  logic [23:0]         area;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pixels_q  <= fbsr_pkg::LINE_PIXELS_RST;
      frame_lines_q  <= fbsr_pkg::FRAME_LINES_RST;
      region_base_q  <= fbsr_pkg::REGION_BASE_RST;
      buffer_bytes_q <= fbsr_pkg::BUFFER_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (fbsr_pkg::cfg_reg_e'(cfg_idx_i))
        fbsr_pkg::REG_LINE_PIXELS:  line_pixels_q  <= cfg_wdata_i[11:0];
        fbsr_pkg::REG_FRAME_LINES:  frame_lines_q  <= cfg_wdata_i[11:0];
        fbsr_pkg::REG_REGION_BASE:  region_base_q  <= cfg_wdata_i;
        fbsr_pkg::REG_BUFFER_BYTES: buffer_bytes_q <= cfg_wdata_i[27:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;
  assign in_xfer   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.event_bits        <= in_i.event_bits;
      in_q.slot0_dma_pending <= in_i.slot0_dma_pending;
      in_q.slot0_write_addr  <= in_i.slot0_write_addr;
      in_q.slot1_dma_pending <= in_i.slot1_dma_pending;
      in_q.slot1_write_addr  <= in_i.slot1_write_addr;
    end
  end

  // shared slot context
  assign area             = 24'(line_pixels_q) * 24'(frame_lines_q);
  assign ctx.region_base  = region_base_q;
  assign ctx.buffer_bytes = buffer_bytes_q;
  assign ctx.expected     = {6'b0, area, 2'b00};
  assign ctx.lo           = region_base_q & fbsr_pkg::OFFSET_MASK;
  assign ctx.hi           = ctx.lo + 32'({4'b0, buffer_bytes_q} * 32'(fbsr_pkg::BUFFER_COUNT));

  assign s0_in = '{event_bit:   in_q.event_bits[0],
                   dma_pending: in_q.slot0_dma_pending,
                   write_addr:  in_q.slot0_write_addr};
  assign s1_in = '{event_bit:   in_q.event_bits[1],
                   dma_pending: in_q.slot1_dma_pending,
                   write_addr:  in_q.slot1_write_addr};

  fbsr_slot u_slot0 (
    .slot_i     (s0_in),
    .ctx_i      (ctx),
    .cur_buf_i  (slot0_buf_q),
    .next_buf_i (next_buf_q),
    .new_buf_o  (slot0_buf_d),
    .res_o      (s0_res)
  );

  // slot 1 sees the rotation index after slot 0 has taken its buffer
  assign next_mid = s0_res.good ? fbsr_pkg::advance(next_buf_q) : next_buf_q;

  fbsr_slot u_slot1 (
    .slot_i     (s1_in),
    .ctx_i      (ctx),
    .cur_buf_i  (slot1_buf_q),
    .next_buf_i (next_mid),
    .new_buf_o  (slot1_buf_d),
    .res_o      (s1_res)
  );

  assign next_buf_d  = s1_res.good ? fbsr_pkg::advance(next_mid) : next_mid;
  // slot 1 goes last, so its good frame wins
  assign shown_buf_d = s1_res.good ? slot1_buf_q :
                       s0_res.good ? slot0_buf_q : shown_buf_q;

  always_comb begin
    out_d.slot0_reload    = s0_res.reload;
    out_d.slot0_load_addr = s0_res.load_addr;
    out_d.slot1_reload    = s1_res.reload;
    out_d.slot1_load_addr = s1_res.load_addr;
    out_d.pending_clear   = {s1_res.clr, s0_res.clr};
    out_d.display_addr    = fbsr_pkg::buf_base(region_base_q, buffer_bytes_q, shown_buf_d);
    out_d.length_error    = {s1_res.len_err, s0_res.len_err};
    out_d.stray_dma       = {s1_res.stray, s0_res.stray};
    out_d.spurious_event  = {s1_res.spur, s0_res.spur};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_buf_q <= fbsr_pkg::buf_idx_t'(0);
      slot1_buf_q <= fbsr_pkg::buf_idx_t'(1);
      next_buf_q  <= fbsr_pkg::buf_idx_t'(1);
      shown_buf_q <= fbsr_pkg::buf_idx_t'(0);
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        slot0_buf_q <= slot0_buf_d;
        slot1_buf_q <= slot1_buf_d;
        next_buf_q  <= next_buf_d;
        shown_buf_q <= shown_buf_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.slot0_reload    = out_q.slot0_reload;
  assign out_o.slot0_load_addr = out_q.slot0_load_addr;
  assign out_o.slot1_reload    = out_q.slot1_reload;
  assign out_o.slot1_load_addr = out_q.slot1_load_addr;
  assign out_o.pending_clear   = out_q.pending_clear;
  assign out_o.display_addr    = out_q.display_addr;
  assign out_o.length_error    = out_q.length_error;
  assign out_o.stray_dma       = out_q.stray_dma;
  assign out_o.spurious_event  = out_q.spurious_event;

  `FBSR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !in_valid_q && !out_valid_q,
                      "pipeline not empty in reset")
  `FBSR_ASSERT(a_idx_range,
               32'(slot0_buf_q) < fbsr_pkg::BUFFER_COUNT &&
               32'(slot1_buf_q) < fbsr_pkg::BUFFER_COUNT &&
               32'(next_buf_q) < fbsr_pkg::BUFFER_COUNT &&
               32'(shown_buf_q) < fbsr_pkg::BUFFER_COUNT,
               "buffer index out of range")
  `FBSR_ASSERT(a_next_hold, !adv |=> $stable(next_buf_q) && $stable(shown_buf_q),
               "rotation state moved without an event")
  `FBSR_ASSERT(a_clear_reload,
               out_valid_q |-> out_q.pending_clear == {out_q.slot1_reload, out_q.slot0_reload},
               "acknowledge differs from reload")
  `FBSR_ASSERT(a_lenerr_reload,
               out_valid_q && out_q.length_error[0] |->
                 out_q.slot0_reload && !out_q.spurious_event[0],
               "slot 0 length error without reload")

endmodule

// ----- hdl/fbsr_slot.sv -----
// per-slot event handling: length check, stray check, buffer swap and reload
// depends on fbsr_pkg
module fbsr_slot (
  input  fbsr_pkg::slot_in_t  slot_i,
  input  fbsr_pkg::slot_ctx_t ctx_i,
  input  fbsr_pkg::buf_idx_t  cur_buf_i,
  input  fbsr_pkg::buf_idx_t  next_buf_i,
  output fbsr_pkg::buf_idx_t  new_buf_o,
  output fbsr_pkg::slot_res_t res_o
);

  logic [31:0] cur_base;
  logic [31:0] next_base;
  logic [31:0] length;
  logic        match;

  assign cur_base  = fbsr_pkg::buf_base(ctx_i.region_base, ctx_i.buffer_bytes, cur_buf_i);
  assign next_base = fbsr_pkg::buf_base(ctx_i.region_base, ctx_i.buffer_bytes, next_buf_i);
  assign length    = slot_i.write_addr - (cur_base & fbsr_pkg::OFFSET_MASK);
  assign match     = (length == ctx_i.expected);

  always_comb begin
    res_o     = '0;
    new_buf_o = cur_buf_i;
    if (slot_i.dma_pending) begin
      res_o.stray  = (slot_i.write_addr < ctx_i.lo) || (slot_i.write_addr > ctx_i.hi);
      res_o.reload = 1'b1;
      res_o.clr    = 1'b1;
      if (match) begin
        // good frame: this buffer goes to display, slot takes the next one
        res_o.good      = 1'b1;
        new_buf_o       = next_buf_i;
        res_o.load_addr = next_base;
      end else begin
        res_o.len_err   = 1'b1;
        res_o.load_addr = cur_base;
      end
    end else if (slot_i.event_bit) begin
      res_o.reload    = 1'b1;
      res_o.clr       = 1'b1;
      res_o.spur      = 1'b1;
      res_o.load_addr = cur_base;
    end
  end

endmodule
